/* hw/rtl/imu_hold_phase_timer_defines.svh */
// ----------------------------------------------------------------------------
// imu_hold_phase_timer_defines
// Assertion macros of the hold phase timer, used by ihpt_core.
// ----------------------------------------------------------------------------
`ifndef IMU_HOLD_PHASE_TIMER_DEFINES_SVH
`define IMU_HOLD_PHASE_TIMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IHPT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IHPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ihpt_pkg.sv */
// ----------------------------------------------------------------------------
// ihpt_pkg
// Types and constants of the IMU hold phase timer.
// ----------------------------------------------------------------------------
package ihpt_pkg;

    localparam logic [1:0] PH_REST   = 2'd0;
    localparam logic [1:0] PH_MOTION = 2'd1;
    localparam logic [1:0] PH_ANCHOR = 2'd2;

    localparam logic [1:0] RSN_NONE  = 2'd0;
    localparam logic [1:0] RSN_OK    = 2'd1;
    localparam logic [1:0] RSN_STALE = 2'd2;

    localparam logic [15:0] NOT_SET  = 16'hFFFF;
    localparam logic [15:0] SAT_MS   = 16'hFFFE;

    localparam logic [15:0] FILTER_ALPHA_Q16 = 16'd1003;
    localparam logic [14:0] GRAVITY_GATE_DEV = 15'd1024;
    localparam logic [63:0] MIN_GRAV_SQ      = 64'd3355443 * 64'd3355443;
    localparam logic [31:0] RECIP_1000       = 32'd274877907;

    localparam logic [2:0] REG_QUIET_RATE = 3'd0;
    localparam logic [2:0] REG_MOVE_RATE  = 3'd1;
    localparam logic [2:0] REG_QUIET_DEV  = 3'd2;
    localparam logic [2:0] REG_POSTURE    = 3'd3;
    localparam logic [2:0] REG_CONFIRM    = 3'd4;
    localparam logic [2:0] REG_ANCHOR_MAX = 3'd5;
    localparam logic [2:0] REG_LATCH_MAX  = 3'd6;
    localparam logic [2:0] REG_GRAV_REF   = 3'd7;

    typedef struct packed {
        logic [14:0] quiet_rate_limit;
        logic [14:0] move_rate_limit;
        logic [14:0] quiet_dev_limit;
        logic [14:0] posture_cos_limit;
        logic [15:0] quiet_confirm_ms;
        logic [22:0] anchor_max_ms;
        logic [15:0] latch_max_ms;
        logic [14:0] gravity_ref;
    } t_cfg;

    typedef struct packed {
        logic        shot_done;
        logic [1:0]  shot_reason;
        logic [15:0] raise_ms;
        logic [15:0] aim_ms;
        logic [22:0] ms_in_phase;
        logic [1:0]  phase_now;
    } t_result;

endpackage

/* hw/rtl/imu_hold_phase_timer.sv */
// ----------------------------------------------------------------------------
// imu_hold_phase_timer
// Hold and anchor phase timer driven by timestamped IMU samples and fire words.
// ----------------------------------------------------------------------------
// Every input word gives exactly one output word. An IMU sample runs through
// the states from ST_RX to ST_FIN before the block can accept again, and a
// fire word through ST_DA to ST_FIN; both sequences are set by the single
// shared 32 x 32 multiplier that every square, filter product, posture product
// and divide by 1000 goes through, one product per cycle. A finished word waits
// in the output register while the next input word is accepted.
module imu_hold_phase_timer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // time_us, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
    input  logic [127:0]  s_axis_tdata,
    // cmd
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // phase_now, ms_in_phase, aim_ms, raise_ms, shot_reason, zero fill
    output logic [63:0]   m_axis_tdata,
    // shot_done
    output logic          m_axis_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    ihpt_pkg::t_cfg    cfg;
    ihpt_pkg::t_result res;

    ihpt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ihpt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (res)
    );

    assign m_axis_tdata = {5'd0, res.shot_reason, res.raise_ms, res.aim_ms,
                           res.ms_in_phase, res.phase_now};
    assign m_axis_tuser = res.shot_done;

endmodule

/* hw/rtl/ihpt_mul.sv */
// ----------------------------------------------------------------------------
// ihpt_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ihpt_mul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= 64'(i_a) * 64'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

/* hw/rtl/ihpt_regs.sv */
// ----------------------------------------------------------------------------
// ihpt_regs
// APB configuration registers of the hold phase timer.
// ----------------------------------------------------------------------------
module ihpt_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output ihpt_pkg::t_cfg      o_cfg
);

    ihpt_pkg::t_cfg r_cfg;
    logic           wr;
    logic [2:0]     idx;

    assign wr  = psel && penable && pwrite;
    assign idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quiet_rate_limit  <= 15'd48;
            r_cfg.move_rate_limit   <= 15'd240;
            r_cfg.quiet_dev_limit   <= 15'd256;
            r_cfg.posture_cos_limit <= 15'd22938;
            r_cfg.quiet_confirm_ms  <= 16'd300;
            r_cfg.anchor_max_ms     <= 23'd60000;
            r_cfg.latch_max_ms      <= 16'd500;
            r_cfg.gravity_ref       <= 15'd5023;
        end else if (wr) begin
            case (idx)
                ihpt_pkg::REG_QUIET_RATE: r_cfg.quiet_rate_limit  <= pwdata[14:0];
                ihpt_pkg::REG_MOVE_RATE:  r_cfg.move_rate_limit   <= pwdata[14:0];
                ihpt_pkg::REG_QUIET_DEV:  r_cfg.quiet_dev_limit   <= pwdata[14:0];
                ihpt_pkg::REG_POSTURE:    r_cfg.posture_cos_limit <= pwdata[14:0];
                ihpt_pkg::REG_CONFIRM:    r_cfg.quiet_confirm_ms  <= pwdata[15:0];
                ihpt_pkg::REG_ANCHOR_MAX: r_cfg.anchor_max_ms     <= pwdata[22:0];
                ihpt_pkg::REG_LATCH_MAX:  r_cfg.latch_max_ms      <= pwdata[15:0];
                ihpt_pkg::REG_GRAV_REF:   r_cfg.gravity_ref       <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            ihpt_pkg::REG_QUIET_RATE: prdata = 32'(r_cfg.quiet_rate_limit);
            ihpt_pkg::REG_MOVE_RATE:  prdata = 32'(r_cfg.move_rate_limit);
            ihpt_pkg::REG_QUIET_DEV:  prdata = 32'(r_cfg.quiet_dev_limit);
            ihpt_pkg::REG_POSTURE:    prdata = 32'(r_cfg.posture_cos_limit);
            ihpt_pkg::REG_CONFIRM:    prdata = 32'(r_cfg.quiet_confirm_ms);
            ihpt_pkg::REG_ANCHOR_MAX: prdata = 32'(r_cfg.anchor_max_ms);
            ihpt_pkg::REG_LATCH_MAX:  prdata = 32'(r_cfg.latch_max_ms);
            ihpt_pkg::REG_GRAV_REF:   prdata = 32'(r_cfg.gravity_ref);
            default:                  prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

/* hw/rtl/ihpt_core.sv */
// ----------------------------------------------------------------------------
// ihpt_core
// Sequencer that runs every product, compare and divide of one word through
// the shared multiplier and updates the phase machine before the last divide.
// ----------------------------------------------------------------------------
`include "imu_hold_phase_timer_defines.svh"

module ihpt_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ihpt_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [127:0]       i_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ihpt_pkg::t_result  o_out
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_RX   = 5'd1;
    localparam logic [4:0] ST_RY   = 5'd2;
    localparam logic [4:0] ST_RZ   = 5'd3;
    localparam logic [4:0] ST_AX   = 5'd4;
    localparam logic [4:0] ST_AY   = 5'd5;
    localparam logic [4:0] ST_AZ   = 5'd6;
    localparam logic [4:0] ST_GLO  = 5'd7;
    localparam logic [4:0] ST_GHI  = 5'd8;
    localparam logic [4:0] ST_QLO  = 5'd9;
    localparam logic [4:0] ST_QHI  = 5'd10;
    localparam logic [4:0] ST_QR   = 5'd11;
    localparam logic [4:0] ST_MR   = 5'd12;
    localparam logic [4:0] ST_F0   = 5'd13;
    localparam logic [4:0] ST_F1   = 5'd14;
    localparam logic [4:0] ST_F2   = 5'd15;
    localparam logic [4:0] ST_G0   = 5'd16;
    localparam logic [4:0] ST_G1   = 5'd17;
    localparam logic [4:0] ST_G2   = 5'd18;
    localparam logic [4:0] ST_C2   = 5'd19;
    localparam logic [4:0] ST_CL   = 5'd20;
    localparam logic [4:0] ST_CH   = 5'd21;
    localparam logic [4:0] ST_DA   = 5'd22;
    localparam logic [4:0] ST_DQ   = 5'd23;
    localparam logic [4:0] ST_DR   = 5'd24;
    localparam logic [4:0] ST_DF   = 5'd25;
    localparam logic [4:0] ST_DEC  = 5'd26;
    localparam logic [4:0] ST_DP   = 5'd27;
    localparam logic [4:0] ST_FIN  = 5'd28;

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        mag16 = v[15] ? 16'(-v) : 16'(v);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [22:0] quot(input logic [63:0] p);
        quot = p[60:38];
    endfunction

    function automatic logic [15:0] sat_ms(input logic [22:0] q);
        sat_ms = (q >= 23'(ihpt_pkg::NOT_SET)) ? ihpt_pkg::SAT_MS : q[15:0];
    endfunction

    logic [4:0]          r_st, r_tag;
    logic                r_cmd;
    logic [31:0]         r_t;
    logic signed [15:0]  r_acc [3];
    logic signed [15:0]  r_rate [3];
    logic [31:0]         r_w2, r_a2;
    logic                r_glo, r_gate, r_qlo, r_qband, r_qrate, r_moving;
    logic signed [31:0]  r_g [3];
    logic                r_dsign, r_primed;
    logic [63:0]         r_g2;
    logic [61:0]         r_gx2;
    logic [29:0]         r_cos2;
    logic [61:0]         r_plo;
    logic                r_post;
    logic [22:0]         r_da, r_dq, r_dr;

    logic [1:0]          r_phase;
    logic [31:0]         r_ps, r_rs, r_as, r_qs, r_lat, r_fz_end;
    logic                r_f_raise, r_f_anchor, r_f_quiet, r_f_closed;
    logic [15:0]         r_fz_aim, r_fz_raise, r_sh_aim, r_sh_raise;
    logic [1:0]          r_sh_reason;
    logic                r_oval;
    ihpt_pkg::t_result   r_o;

    logic [1:0]          n_phase;
    logic [31:0]         n_ps, n_rs, n_as, n_qs, n_lat, n_fz_end;
    logic                n_f_raise, n_f_anchor, n_f_quiet, n_f_closed;
    logic [15:0]         n_fz_aim, n_fz_raise, n_sh_aim, n_sh_raise;
    logic [1:0]          n_sh_reason;

    logic                mul_en;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         prod;
    logic [15:0]         gate_lo, gate_hi, q_lo, q_hi;
    logic                gate_lo_neg, q_lo_neg;
    logic signed [32:0]  fd;
    logic [31:0]         fd_mag;
    logic signed [63:0]  fstep;
    logic signed [63:0]  fsum;
    logic [93:0]         post_rhs, post_lhs;
    logic [31:0]         gap;
    logic [15:0]         c_aim, c_raise;
    logic [22:0]         age;
    logic                fin_go;

    assign gate_lo     = 16'(i_cfg.gravity_ref) - 16'(ihpt_pkg::GRAVITY_GATE_DEV);
    assign gate_hi     = 16'(i_cfg.gravity_ref) + 16'(ihpt_pkg::GRAVITY_GATE_DEV);
    assign gate_lo_neg = i_cfg.gravity_ref < ihpt_pkg::GRAVITY_GATE_DEV;
    assign q_lo        = 16'(i_cfg.gravity_ref) - 16'(i_cfg.quiet_dev_limit);
    assign q_hi        = 16'(i_cfg.gravity_ref) + 16'(i_cfg.quiet_dev_limit);
    assign q_lo_neg    = i_cfg.gravity_ref < i_cfg.quiet_dev_limit;

    always_comb begin
        fd = 33'sd0;
        case (r_st)
            ST_F0:   fd = $signed({r_acc[0][15], r_acc[0], 16'd0}) - $signed({r_g[0][31], r_g[0]});
            ST_F1:   fd = $signed({r_acc[1][15], r_acc[1], 16'd0}) - $signed({r_g[1][31], r_g[1]});
            ST_F2:   fd = $signed({r_acc[2][15], r_acc[2], 16'd0}) - $signed({r_g[2][31], r_g[2]});
            default: fd = 33'sd0;
        endcase
    end

    assign fd_mag = fd[32] ? 32'(-fd) : 32'(fd);

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_st)
            ST_RX:  begin mul_a = 32'(mag16(r_rate[0])); mul_b = mul_a; end
            ST_RY:  begin mul_a = 32'(mag16(r_rate[1])); mul_b = mul_a; end
            ST_RZ:  begin mul_a = 32'(mag16(r_rate[2])); mul_b = mul_a; end
            ST_AX:  begin mul_a = 32'(mag16(r_acc[0])); mul_b = mul_a; end
            ST_AY:  begin mul_a = 32'(mag16(r_acc[1])); mul_b = mul_a; end
            ST_AZ:  begin mul_a = 32'(mag16(r_acc[2])); mul_b = mul_a; end
            ST_GLO: begin mul_a = 32'(gate_lo); mul_b = mul_a; end
            ST_GHI: begin mul_a = 32'(gate_hi); mul_b = mul_a; end
            ST_QLO: begin mul_a = 32'(q_lo); mul_b = mul_a; end
            ST_QHI: begin mul_a = 32'(q_hi); mul_b = mul_a; end
            ST_QR:  begin mul_a = 32'(i_cfg.quiet_rate_limit); mul_b = mul_a; end
            ST_MR:  begin mul_a = 32'(i_cfg.move_rate_limit); mul_b = mul_a; end
            ST_F0, ST_F1, ST_F2: begin
                mul_a = fd_mag;
                mul_b = 32'(ihpt_pkg::FILTER_ALPHA_Q16);
            end
            ST_G0:  begin mul_a = mag32(r_g[0]); mul_b = mul_a; end
            ST_G1:  begin mul_a = mag32(r_g[1]); mul_b = mul_a; end
            ST_G2:  begin mul_a = mag32(r_g[2]); mul_b = mul_a; end
            ST_C2:  begin mul_a = 32'(i_cfg.posture_cos_limit); mul_b = mul_a; end
            ST_CL:  begin mul_a = prod[31:0]; mul_b = r_g2[31:0]; end
            ST_CH:  begin mul_a = 32'(r_cos2); mul_b = r_g2[63:32]; end
            ST_DA:  begin mul_a = r_t - r_as; mul_b = ihpt_pkg::RECIP_1000; end
            ST_DQ:  begin mul_a = r_t - r_qs; mul_b = ihpt_pkg::RECIP_1000; end
            ST_DR:  begin mul_a = r_as - r_rs; mul_b = ihpt_pkg::RECIP_1000; end
            ST_DF:  begin mul_a = r_t - r_fz_end; mul_b = ihpt_pkg::RECIP_1000; end
            ST_DP:  begin mul_a = r_lat - r_ps; mul_b = ihpt_pkg::RECIP_1000; end
            default: begin mul_a = 32'd0; mul_b = 32'd0; end
        endcase
    end

    assign mul_en = ((r_st >= ST_RX) && (r_st <= ST_DF)) || (r_st == ST_DP);

    ihpt_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign fstep    = r_dsign ? -$signed({16'd0, prod[47:0]}) : $signed({16'd0, prod[47:0]});
    assign fsum     = (fstep + 64'sd32768) >>> 16;
    assign post_rhs = {prod[61:0], 32'd0} + {32'd0, r_plo};
    assign post_lhs = {2'd0, r_gx2, 30'd0};

    // Closing an anchor freezes its length and the raise time before it.
    assign gap     = r_as - r_rs;
    assign c_aim   = sat_ms(r_da);
    assign c_raise = (r_f_raise && (gap != 32'd0) && !gap[31]) ? sat_ms(r_dr)
                                                               : ihpt_pkg::NOT_SET;
    assign age     = r_f_anchor ? 23'd0 : quot(prod);

    always_comb begin
        n_phase     = r_phase;
        n_ps        = r_ps;
        n_rs        = r_rs;
        n_as        = r_as;
        n_qs        = r_qs;
        n_lat       = r_lat;
        n_fz_end    = r_fz_end;
        n_fz_aim    = r_fz_aim;
        n_fz_raise  = r_fz_raise;
        n_f_raise   = r_f_raise;
        n_f_anchor  = r_f_anchor;
        n_f_quiet   = r_f_quiet;
        n_f_closed  = r_f_closed;
        n_sh_aim    = r_sh_aim;
        n_sh_raise  = r_sh_raise;
        n_sh_reason = r_sh_reason;
        if (r_cmd) begin
            n_sh_aim    = ihpt_pkg::NOT_SET;
            n_sh_raise  = ihpt_pkg::NOT_SET;
            n_sh_reason = ihpt_pkg::RSN_NONE;
            if (r_f_anchor) begin
                n_fz_aim   = c_aim;
                n_fz_raise = c_raise;
                n_fz_end   = r_t;
            end
            if (r_f_anchor || r_f_closed) begin
                if (age <= 23'(i_cfg.latch_max_ms)) begin
                    n_sh_aim    = n_fz_aim;
                    n_sh_raise  = n_fz_raise;
                    n_sh_reason = ihpt_pkg::RSN_OK;
                end else begin
                    n_sh_reason = ihpt_pkg::RSN_STALE;
                end
            end
            n_phase    = ihpt_pkg::PH_REST;
            n_ps       = r_t;
            n_f_raise  = 1'b0;
            n_f_anchor = 1'b0;
            n_f_quiet  = 1'b0;
            n_f_closed = 1'b0;
        end else begin
            n_lat = r_t;
            if (!r_post) begin
                if (r_f_anchor) begin
                    n_fz_aim   = c_aim;
                    n_fz_raise = c_raise;
                    n_fz_end   = r_t;
                    n_f_closed = 1'b1;
                    n_f_anchor = 1'b0;
                end
                if (r_phase != ihpt_pkg::PH_REST) begin
                    n_phase = ihpt_pkg::PH_REST;
                    n_ps    = r_t;
                end
                n_f_quiet = 1'b0;
                n_f_raise = 1'b0;
            end else if ((r_phase == ihpt_pkg::PH_ANCHOR) && (r_da > i_cfg.anchor_max_ms)) begin
                n_phase    = ihpt_pkg::PH_REST;
                n_ps       = r_t;
                n_f_anchor = 1'b0;
                n_f_quiet  = 1'b0;
            end else if (r_moving) begin
                if (r_f_anchor) begin
                    n_fz_aim   = c_aim;
                    n_fz_raise = c_raise;
                    n_fz_end   = r_t;
                    n_f_closed = 1'b1;
                    n_f_anchor = 1'b0;
                end
                if (r_phase != ihpt_pkg::PH_MOTION) begin
                    n_phase   = ihpt_pkg::PH_MOTION;
                    n_ps      = r_t;
                    n_rs      = r_t;
                    n_f_raise = 1'b1;
                end
                n_f_quiet = 1'b0;
            end else if (r_qrate && r_qband) begin
                if (!r_f_quiet) begin
                    n_f_quiet = 1'b1;
                    n_qs      = r_t;
                end else if ((r_phase != ihpt_pkg::PH_ANCHOR) &&
                             (r_dq >= 23'(i_cfg.quiet_confirm_ms))) begin
                    n_phase    = ihpt_pkg::PH_ANCHOR;
                    n_as       = r_qs;
                    n_ps       = r_qs;
                    n_f_anchor = 1'b1;
                end
            end else begin
                n_f_quiet = 1'b0;
            end
        end
    end

    assign fin_go = (r_st == ST_FIN) && (!r_oval || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_tag       <= ST_IDLE;
            r_oval      <= 1'b0;
            r_primed    <= 1'b0;
            r_g[0]      <= 32'sd0;
            r_g[1]      <= 32'sd0;
            r_g[2]      <= 32'sd0;
            r_phase     <= ihpt_pkg::PH_REST;
            r_ps        <= 32'd0;
            r_rs        <= 32'd0;
            r_as        <= 32'd0;
            r_qs        <= 32'd0;
            r_lat       <= 32'd0;
            r_fz_end    <= 32'd0;
            r_fz_aim    <= ihpt_pkg::NOT_SET;
            r_fz_raise  <= ihpt_pkg::NOT_SET;
            r_f_raise   <= 1'b0;
            r_f_anchor  <= 1'b0;
            r_f_quiet   <= 1'b0;
            r_f_closed  <= 1'b0;
            r_sh_aim    <= ihpt_pkg::NOT_SET;
            r_sh_raise  <= ihpt_pkg::NOT_SET;
            r_sh_reason <= ihpt_pkg::RSN_NONE;
        end else begin
            r_tag <= r_st;
            if (fin_go) begin
                r_oval <= 1'b1;
            end else if (r_oval && i_out_ready) begin
                r_oval <= 1'b0;
            end
            if ((r_st == ST_F0) || (r_st == ST_F1) || (r_st == ST_F2)) begin
                r_dsign <= fd[32];
            end

            case (r_tag)
                ST_RX:  r_w2 <= prod[31:0];
                ST_RY:  r_w2 <= r_w2 + prod[31:0];
                ST_RZ:  r_w2 <= r_w2 + prod[31:0];
                ST_AX:  r_a2 <= prod[31:0];
                ST_AY:  r_a2 <= r_a2 + prod[31:0];
                ST_AZ:  r_a2 <= r_a2 + prod[31:0];
                ST_GLO: r_glo <= gate_lo_neg || (r_a2 > prod[31:0]);
                ST_GHI: r_gate <= r_glo && (r_a2 < prod[31:0]);
                ST_QLO: r_qlo <= q_lo_neg || (r_a2 > prod[31:0]);
                ST_QHI: r_qband <= r_qlo && (r_a2 < prod[31:0]);
                ST_QR:  r_qrate <= r_w2 < prod[31:0];
                ST_MR:  r_moving <= r_w2 > prod[31:0];
                ST_F0: begin
                    if (!r_primed) begin
                        r_g[0] <= $signed({r_acc[0], 16'd0});
                    end else if (r_gate) begin
                        r_g[0] <= r_g[0] + $signed(fsum[31:0]);
                    end
                end
                ST_F1: begin
                    if (!r_primed) begin
                        r_g[1] <= $signed({r_acc[1], 16'd0});
                    end else if (r_gate) begin
                        r_g[1] <= r_g[1] + $signed(fsum[31:0]);
                    end
                end
                ST_F2: begin
                    if (!r_primed) begin
                        r_g[2] <= $signed({r_acc[2], 16'd0});
                    end else if (r_gate) begin
                        r_g[2] <= r_g[2] + $signed(fsum[31:0]);
                    end
                    r_primed <= 1'b1;
                end
                ST_G0: begin
                    r_g2  <= prod;
                    r_gx2 <= prod[61:0];
                end
                ST_G1:  r_g2 <= r_g2 + prod;
                ST_G2:  r_g2 <= r_g2 + prod;
                ST_C2:  r_cos2 <= prod[29:0];
                ST_CL:  r_plo <= prod[61:0];
                ST_CH:  r_post <= (r_g2 > ihpt_pkg::MIN_GRAV_SQ) && !r_g[0][31] &&
                                  (r_g[0] != 32'sd0) && (post_lhs > post_rhs);
                ST_DA:  r_da <= quot(prod);
                ST_DQ:  r_dq <= quot(prod);
                ST_DR:  r_dr <= quot(prod);
                default: ;
            endcase

            case (r_st)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd     <= i_cmd;
                        r_t       <= i_data[31:0];
                        r_acc[0]  <= $signed(i_data[47:32]);
                        r_acc[1]  <= $signed(i_data[63:48]);
                        r_acc[2]  <= $signed(i_data[79:64]);
                        r_rate[0] <= $signed(i_data[95:80]);
                        r_rate[1] <= $signed(i_data[111:96]);
                        r_rate[2] <= $signed(i_data[127:112]);
                        r_st      <= i_cmd ? ST_DA : ST_RX;
                    end
                end
                ST_DEC: begin
                    r_phase     <= n_phase;
                    r_ps        <= n_ps;
                    r_rs        <= n_rs;
                    r_as        <= n_as;
                    r_qs        <= n_qs;
                    r_lat       <= n_lat;
                    r_fz_end    <= n_fz_end;
                    r_fz_aim    <= n_fz_aim;
                    r_fz_raise  <= n_fz_raise;
                    r_f_raise   <= n_f_raise;
                    r_f_anchor  <= n_f_anchor;
                    r_f_quiet   <= n_f_quiet;
                    r_f_closed  <= n_f_closed;
                    r_sh_aim    <= n_sh_aim;
                    r_sh_raise  <= n_sh_raise;
                    r_sh_reason <= n_sh_reason;
                    r_st        <= ST_DP;
                end
                ST_FIN: begin
                    if (fin_go) begin
                        r_o.phase_now <= r_phase;
                        r_o.ms_in_phase <= (r_ps == 32'd0) ? 23'd0 : quot(prod);
                        r_o.aim_ms      <= r_sh_aim;
                        r_o.raise_ms    <= r_sh_raise;
                        r_o.shot_reason <= r_sh_reason;
                        r_o.shot_done   <= r_cmd;
                        r_st            <= ST_IDLE;
                    end
                end
                default: r_st <= r_st + 5'd1;
            endcase
        end
    end

    assign o_in_ready  = (r_st == ST_IDLE);
    assign o_out_valid = r_oval;
    assign o_out       = r_o;

    `IHPT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, r_st != ST_IDLE, "accepted word did not start the sequencer")
    `IHPT_ASSERT_IMPL(a_anchor_flag_phase, 1'b1, r_f_anchor == (r_phase == ihpt_pkg::PH_ANCHOR), "open anchor flag disagrees with phase")
    `IHPT_ASSERT_NEXT(a_fin_delivers, fin_go, r_oval && (r_st == ST_IDLE), "finished word was not presented")

endmodule
